// ===== rtl/core/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constant tables for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;
  // Working / chaining vector, index 0 is word a (most significant digest word)
  typedef word_t [7:0] hvec_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage
`default_nettype wire

// ===== rtl/core/sha_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sha_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round and the message schedule expansion word.
// ----------------------------------------------------------------------------
module sha_round (
  input  wire sha_pkg::hvec_t v_i,
  input  wire sha_pkg::word_t k_i,
  input  wire sha_pkg::word_t w_i,
  input  wire sha_pkg::word_t w_m16_i,
  input  wire sha_pkg::word_t w_m15_i,
  input  wire sha_pkg::word_t w_m7_i,
  input  wire sha_pkg::word_t w_m2_i,
  output sha_pkg::hvec_t v_o,
  output sha_pkg::word_t sched_o
);
  import sha_pkg::*;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t big_s0, big_s1, ch, maj, t1, t2, sm_s0, sm_s1;

  always_comb begin
    big_s1 = rotr(v_i[4], 6) ^ rotr(v_i[4], 11) ^ rotr(v_i[4], 25);
    big_s0 = rotr(v_i[0], 2) ^ rotr(v_i[0], 13) ^ rotr(v_i[0], 22);
    ch     = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj    = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1     = v_i[7] + big_s1 + ch + k_i + w_i;
    t2     = big_s0 + maj;

    v_o[0] = t1 + t2;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];

    sm_s0   = rotr(w_m15_i, 7) ^ rotr(w_m15_i, 18) ^ (w_m15_i >> 3);
    sm_s1   = rotr(w_m2_i, 17) ^ rotr(w_m2_i, 19) ^ (w_m2_i >> 10);
    sched_o = w_m16_i + sm_s0 + w_m7_i + sm_s1;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: one message byte per input item, eight digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i  : one item per cycle while ready is high. has_byte marks a valid
//              data_byte; end_of_message closes the message after its byte.
//   out_ch_o : eight items per message, word_index 0..7, last_word on 7.
// Timing:
//   A byte that does not complete a block is taken while the hasher stays
//   idle. Bytes are packed into 32-bit words held in a 16-entry block memory.
//   Every 64th byte starts a compression: ST_CLOAD reads the chain memory
//   into the working registers, 64 rounds run (one per cycle through the
//   round unit), and ST_CADD adds the result back into the chain memory.
//   End of message: one or two padding passes of up to 16 word writes
//   each, each followed by a compression, then each digest word is read
//   from the chain memory, loaded and held until the receiver is ready.
//   in_ch_i.ready is low during a compression and from end of message until
//   the last digest word is taken; a stalled receiver holds the output word.
// Reset:
//   Clears the chain valid bits so the chain memory reads as the initial
//   hash, and zeroes the fill and bit counters. No clearing pass is needed;
//   the same happens after each digest so the next message starts fresh.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sha_in_if.sink     in_ch_i,
  sha_out_if.source  out_ch_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_CLOAD, ST_ROUND, ST_CADD, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
  } state_e;

  localparam logic [3:0] CNT_LAST = 4'd8;

  state_e        state_q, state_d;
  logic [5:0]    fill_q, fill_d;
  logic [23:0]   acc_q, acc_d;       // earlier bytes of the word being packed
  logic [63:0]   bitcnt_q, bitcnt_d;
  logic [3:0]    cnt_q, cnt_d;       // chain read/add sweep
  logic [5:0]    rnd_q, rnd_d;
  logic [3:0]    wp_q, wp_d;         // padding word pointer
  logic          first_q, first_d;   // next pad word carries the 0x80
  logic          len_q, len_d;       // this pad pass ends with the length
  logic          pad_pend_q, pad_pend_d;
  logic          pad2_q, pad2_d;
  logic          final_q, final_d;
  logic [2:0]    oidx_q, oidx_d;
  logic          out_valid_q, out_valid_d;
  word_t         out_word_q, out_word_d;
  hvec_t         v_q, v_d;
  word_t [15:0]  w_q, w_d;           // schedule window, 0 is oldest
  logic [7:0]    cv_vld_q, cv_vld_d;

  // block memory
  word_t         blk_mem [16];
  logic          blk_we;
  logic [3:0]    blk_waddr, blk_raddr;
  word_t         blk_wdata, blk_rdata_q;

  // chain memory
  word_t         cv_mem [8];
  logic          cv_we;
  logic [2:0]    cv_waddr, cv_raddr, cv_raddr_q;
  word_t         cv_wdata, cv_rdata_q, cv_eff;
  logic          cv_rvld_q;

  hvec_t         v_next;
  word_t         sched_w, round_w, pad_word;
  logic          in_acc;

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata_q <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cv_we) begin
      cv_mem[cv_waddr] <= cv_wdata;
    end
    cv_rdata_q <= cv_mem[cv_raddr];
    cv_rvld_q  <= cv_vld_q[cv_raddr];
    cv_raddr_q <= cv_raddr;
  end

  // never-written chain entries read as the initial hash
  assign cv_eff = cv_rvld_q ? cv_rdata_q : INIT_H[cv_raddr_q];

  assign round_w = (rnd_q < 6'd16) ? blk_rdata_q : sched_w;

  sha_round u_round (
    .v_i     (v_q),
    .k_i     (ROUND_K[rnd_q]),
    .w_i     (round_w),
    .w_m16_i (w_q[0]),
    .w_m15_i (w_q[1]),
    .w_m7_i  (w_q[9]),
    .w_m2_i  (w_q[14]),
    .v_o     (v_next),
    .sched_o (sched_w)
  );

  always_comb begin
    unique case (fill_q[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h000000};
      2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0000};
      2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h00};
      default: pad_word = {acc_q[23:0], PAD_BYTE};
    endcase
  end

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    bitcnt_d    = bitcnt_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    wp_d        = wp_q;
    first_d     = first_q;
    len_d       = len_q;
    pad_pend_d  = pad_pend_q;
    pad2_d      = pad2_q;
    final_d     = final_q;
    oidx_d      = oidx_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    v_d         = v_q;
    w_d         = w_q;
    cv_vld_d    = cv_vld_q;

    blk_we    = 1'b0;
    blk_waddr = fill_q[5:2];
    blk_wdata = {acc_q, in_ch_i.data_byte};
    blk_raddr = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

    cv_we    = 1'b0;
    cv_waddr = cnt_q[2:0] - 3'd1;
    cv_wdata = cv_eff + v_q[0];
    cv_raddr = (state_q == ST_OUT_RD) ? oidx_q : cnt_q[2:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch_i.has_byte) begin
            acc_d    = {acc_q[15:0], in_ch_i.data_byte};
            fill_d   = fill_q + 6'd1;
            bitcnt_d = bitcnt_q + 64'd8;
            blk_we   = (fill_q[1:0] == 2'b11);
          end
          if (in_ch_i.has_byte && (fill_q == 6'd63)) begin
            state_d    = ST_CLOAD;
            cnt_d      = '0;
            pad_pend_d = in_ch_i.end_of_message;
          end else if (in_ch_i.end_of_message) begin
            state_d = ST_PAD;
            wp_d    = fill_d[5:2];
            first_d = 1'b1;
            len_d   = (fill_d < 6'd56);
          end
        end
      end

      ST_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = wp_q;
        if (first_q) begin
          blk_wdata = pad_word;
        end else if (len_q && (wp_q == 4'd14)) begin
          blk_wdata = bitcnt_q[63:32];
        end else if (len_q && (wp_q == 4'd15)) begin
          blk_wdata = bitcnt_q[31:0];
        end else begin
          blk_wdata = '0;
        end
        first_d = 1'b0;
        if (wp_q == 4'd15) begin
          state_d    = ST_CLOAD;
          cnt_d      = '0;
          pad_pend_d = 1'b0;
          final_d    = len_q;
          pad2_d     = !len_q;
        end else begin
          wp_d = wp_q + 4'd1;
        end
      end

      ST_CLOAD: begin
        if (cnt_q != 4'd0) begin
          v_d = {cv_eff, v_q[7:1]};
        end
        if (cnt_q == CNT_LAST) begin
          state_d = ST_ROUND;
          rnd_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end

      ST_ROUND: begin
        v_d   = v_next;
        w_d   = {round_w, w_q[15:1]};
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_CADD;
          cnt_d   = '0;
        end
      end

      ST_CADD: begin
        if (cnt_q != 4'd0) begin
          cv_we              = 1'b1;
          cv_vld_d[cv_waddr] = 1'b1;
          v_d                = {v_q[0], v_q[7:1]};
        end
        if (cnt_q == CNT_LAST) begin
          if (final_q) begin
            state_d = ST_OUT_RD;
            oidx_d  = '0;
            final_d = 1'b0;
          end else if (pad_pend_q) begin
            // message ended on a block boundary: pad a fresh block
            state_d    = ST_PAD;
            pad_pend_d = 1'b0;
            wp_d       = '0;
            first_d    = 1'b1;
            len_d      = 1'b1;
          end else if (pad2_q) begin
            // length did not fit: an all-zero block with the length
            state_d = ST_PAD;
            pad2_d  = 1'b0;
            wp_d    = '0;
            first_d = 1'b0;
            len_d   = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end

      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        out_word_d  = cv_eff;
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WAIT;
      end

      ST_OUT_WAIT: begin
        if (out_ch_o.ready) begin
          out_valid_d = 1'b0;
          if (oidx_q == 3'd7) begin
            state_d  = ST_IDLE;
            cv_vld_d = '0;
            fill_d   = '0;
            bitcnt_d = '0;
          end else begin
            oidx_d  = oidx_q + 3'd1;
            state_d = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bitcnt_q    <= '0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      wp_q        <= '0;
      first_q     <= 1'b0;
      len_q       <= 1'b0;
      pad_pend_q  <= 1'b0;
      pad2_q      <= 1'b0;
      final_q     <= 1'b0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      cv_vld_q    <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bitcnt_q    <= bitcnt_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      wp_q        <= wp_d;
      first_q     <= first_d;
      len_q       <= len_d;
      pad_pend_q  <= pad_pend_d;
      pad2_q      <= pad2_d;
      final_q     <= final_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
      cv_vld_q    <= cv_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
    v_q        <= v_d;
    w_q        <= w_d;
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.digest_word = out_word_q;
  assign out_ch_o.word_index  = oidx_q;
  assign out_ch_o.last_word   = (oidx_q == 3'd7);

  // no new bytes while a digest word is pending
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch_i.ready && out_valid_q))
    else $error("input taken while digest word pending");

  // digest only goes out once all padding passes are done
  a_out_after_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(pad_pend_q || pad2_q || final_q))
    else $error("digest word with padding still pending");

  a_round_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_CADD))
    else $error("round loop did not hand over to chain update");

  // last digest word restarts the message
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_WAIT && out_ch_o.ready && oidx_q == 3'd7)
    |=> (cv_vld_q == 8'd0 && bitcnt_q == 64'd0 && fill_q == 6'd0))
    else $error("state not returned to start of message");

endmodule
`default_nettype wire
